[hw/rtl/loser_tree_kway_merge_macros.svh]
// ---------------------------------------------------------------------------
// Loser tree merge assertion macros
// Shared concurrent assertion forms for the merge RTL.
// ---------------------------------------------------------------------------
`ifndef LOSER_TREE_KWAY_MERGE_MACROS_SVH
`define LOSER_TREE_KWAY_MERGE_MACROS_SVH

// same-cycle implication
`define LTKM_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTKM_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ltkm_pkg.sv]
// ---------------------------------------------------------------------------
// Loser tree merge package
// Operation codes, fixed field widths and the run_count reset value.
// ---------------------------------------------------------------------------
`default_nettype none

package ltkm_pkg;

    localparam int OP_W        = 2;
    localparam int RUN_FIELD_W = 3;
    localparam int CFG_W       = 4;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
    localparam logic [OP_W-1:0] OP_EXHAUST = 2'd3;

    localparam logic [CFG_W-1:0] RUN_COUNT_RST = 4'd8;

endpackage

`default_nettype wire

[hw/rtl/loser_tree_kway_merge.sv]
// ---------------------------------------------------------------------------
// Loser tree k-way merge
// Tournament merge of up to WAYS sorted runs, losers kept in a node RAM.
// ---------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data writes run_count; write only while idle.
//   s_axis carries one request: tuser = operation, tdata = run_index, key.
//   Load writes a run head and gives no result. Start, advance and exhaust
//   each give one result on m_axis: tdata = winner_run, winner_key,
//   tuser = all_done. Advance or exhaust outside a merge gives no result.
// Request handling:
//   One request at a time. Advance and exhaust walk the winner's leaf-to-root
//   path, one node RAM read-modify-write per level, over L = ceil(log2(WAYS))
//   levels (3 for eight runs). Start rebuilds the tree leaf by leaf through
//   the head RAM and node RAM.
// Reset:
//   All runs inactive, no merge in progress, run_count = 8, no clearing pass.
// Stalls:
//   A finished result waits in the output register; while it is not taken a
//   following result holds the block and s_axis_tready stays low.
// ---------------------------------------------------------------------------
`default_nettype none
`include "loser_tree_kway_merge_macros.svh"

module loser_tree_kway_merge
    import ltkm_pkg::*;
#(
    parameter int WAYS     = 8,
    parameter int KEY_BITS = 32,
    localparam int DATA_W  = ((RUN_FIELD_W + KEY_BITS + 7) / 8) * 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,       // run_count
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // run_index, key, zero pad
    input  wire logic [OP_W-1:0]   s_axis_tuser,   // operation
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,   // winner_run, winner_key, zero pad
    output logic [0:0]             m_axis_tuser    // all_done
);

    localparam int RUN_W = $clog2(WAYS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEAF = 2'd1;
    localparam logic [1:0] ST_WALK = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    typedef struct packed {
        logic [RUN_W-1:0]    run;
        logic [KEY_BITS-1:0] key;
        logic                act;
    } node_t;

    function automatic logic beats(input node_t a, input node_t b);
        if (a.act != b.act)
            return a.act;
        if (a.act && (a.key != b.key))
            return $signed(a.key) < $signed(b.key);
        return a.run < b.run;
    endfunction

    function automatic logic [RUN_W-1:0] leaf_node(input logic [RUN_W-1:0] leaf);
        logic [RUN_W:0] sum;
        sum = {1'b0, leaf} + (RUN_W+1)'(WAYS);
        return sum[RUN_W:1];
    endfunction

    // memories
    logic [KEY_BITS-1:0] head_mem [WAYS];
    node_t               node_mem [WAYS];

    logic [KEY_BITS-1:0] head_rdata;
    node_t               node_rdata;
    logic [RUN_W-1:0]    head_raddr;
    logic [RUN_W-1:0]    node_raddr;
    logic                head_we;
    logic [RUN_W-1:0]    head_waddr;
    logic [KEY_BITS-1:0] head_wdata;
    logic                node_we;

    // control and state
    logic [1:0]          state_reg, state_next;
    logic [CFG_W-1:0]    run_count_reg;
    logic [WAYS-1:0]     run_active_reg, run_active_next;
    logic [WAYS-1:0]     node_valid_reg, node_valid_next;
    logic                merging_reg, merging_next;
    logic                building_reg, building_next;
    logic [RUN_W-1:0]    bld_leaf_reg, bld_leaf_next;
    logic [RUN_W-1:0]    t_reg, t_next;
    node_t               cur_reg, cur_next;
    logic                cur_vld_reg, cur_vld_next;
    node_t               win_reg, win_next;
    logic                m_valid_reg, m_valid_next;
    logic [RUN_FIELD_W-1:0] out_run_reg, out_run_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic                out_done_reg, out_done_next;

    logic                   s_acc;
    logic [OP_W-1:0]        in_op;
    logic [RUN_FIELD_W-1:0] in_run;
    logic [KEY_BITS-1:0]    in_key;
    logic [RUN_W-1:0]       in_leaf;
    logic                   swap;
    node_t                  walk_cur;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_run        = s_axis_tdata[RUN_FIELD_W-1:0];
    assign in_key        = s_axis_tdata[RUN_FIELD_W +: KEY_BITS];
    assign in_leaf       = RUN_W'(in_run);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = DATA_W'({out_key_reg, out_run_reg});
    assign m_axis_tuser  = out_done_reg;

    assign head_raddr = (state_reg == ST_IDLE) ? RUN_W'(WAYS - 1) : (bld_leaf_reg - 1'b1);

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: node_raddr = leaf_node(win_reg.run);
            ST_LEAF: node_raddr = leaf_node(bld_leaf_reg);
            default: node_raddr = t_reg >> 1;
        endcase
    end

    always_comb
    begin
        if (!node_valid_reg[t_reg])
            swap = 1'b1;
        else if (!cur_vld_reg)
            swap = 1'b0;
        else
            swap = beats(node_rdata, cur_reg);
        walk_cur = swap ? node_rdata : cur_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        run_active_next = run_active_reg;
        node_valid_next = node_valid_reg;
        merging_next    = merging_reg;
        building_next   = building_reg;
        bld_leaf_next   = bld_leaf_reg;
        t_next          = t_reg;
        cur_next        = cur_reg;
        cur_vld_next    = cur_vld_reg;
        win_next        = win_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_run_next    = out_run_reg;
        out_key_next    = out_key_reg;
        out_done_next   = out_done_reg;
        head_we         = 1'b0;
        head_waddr      = in_leaf;
        head_wdata      = in_key;
        node_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    unique case (in_op)
                        OP_LOAD:
                        begin
                            if (({1'b0, in_run} < run_count_reg) && (int'(in_run) < WAYS))
                            begin
                                head_we                  = 1'b1;
                                run_active_next[in_leaf] = 1'b1;
                                merging_next             = 1'b0;
                            end
                        end
                        OP_START:
                        begin
                            for (int i = 0; i < WAYS; i++)
                            begin
                                if (i >= int'(run_count_reg))
                                    run_active_next[i] = 1'b0;
                            end
                            node_valid_next = '0;
                            bld_leaf_next   = RUN_W'(WAYS - 1);
                            building_next   = 1'b1;
                            state_next      = ST_LEAF;
                        end
                        OP_ADVANCE, OP_EXHAUST:
                        begin
                            if (merging_reg)
                            begin
                                if (win_reg.act)
                                begin
                                    cur_next.run = win_reg.run;
                                    cur_vld_next = 1'b1;
                                    t_next       = node_raddr;
                                    if (in_op == OP_ADVANCE)
                                    begin
                                        cur_next.key = in_key;
                                        cur_next.act = 1'b1;
                                        head_we      = 1'b1;
                                        head_waddr   = win_reg.run;
                                    end
                                    else
                                    begin
                                        cur_next.key = win_reg.key;
                                        cur_next.act = 1'b0;
                                        run_active_next[win_reg.run] = 1'b0;
                                    end
                                    state_next = ST_WALK;
                                end
                                else
                                begin
                                    state_next = ST_OUT;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_LEAF:
            begin
                cur_next.run = bld_leaf_reg;
                cur_next.key = head_rdata;
                cur_next.act = run_active_reg[bld_leaf_reg];
                cur_vld_next = 1'b1;
                t_next       = node_raddr;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                if (swap)
                begin
                    node_we                = 1'b1;
                    node_valid_next[t_reg] = cur_vld_reg;
                    cur_next               = node_rdata;
                    cur_vld_next           = node_valid_reg[t_reg];
                end
                if (t_reg == RUN_W'(1))
                begin
                    win_next = walk_cur;
                    if (building_reg && (bld_leaf_reg != '0))
                    begin
                        bld_leaf_next = bld_leaf_reg - 1'b1;
                        state_next    = ST_LEAF;
                    end
                    else
                    begin
                        building_next = 1'b0;
                        merging_next  = 1'b1;
                        state_next    = ST_OUT;
                    end
                end
                else
                begin
                    t_next = node_raddr;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next  = 1'b1;
                    out_done_next = !win_reg.act;
                    out_run_next  = win_reg.act ? RUN_FIELD_W'(win_reg.run) : '0;
                    out_key_next  = win_reg.act ? win_reg.key : '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_waddr] <= head_wdata;
        head_rdata <= head_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[t_reg] <= cur_reg;
        node_rdata <= node_mem[node_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_count_reg  <= RUN_COUNT_RST;
            run_active_reg <= '0;
            node_valid_reg <= '0;
            merging_reg    <= 1'b0;
            building_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_active_reg <= run_active_next;
            node_valid_reg <= node_valid_next;
            merging_reg    <= merging_next;
            building_reg   <= building_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready)
                run_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        bld_leaf_reg <= bld_leaf_next;
        t_reg        <= t_next;
        cur_reg      <= cur_next;
        cur_vld_reg  <= cur_vld_next;
        win_reg      <= win_next;
        out_run_reg  <= out_run_next;
        out_key_reg  <= out_key_next;
        out_done_reg <= out_done_next;
    end

    `LTKM_ASSERT_IMP(a_tree_full, clk, rst_n, (state_reg == ST_IDLE) && merging_reg && !building_reg, &node_valid_reg[WAYS-1:1], "merge in progress with empty tree node")
    `LTKM_ASSERT_IMP(a_win_active, clk, rst_n, (state_reg == ST_OUT) && win_reg.act, run_active_reg[win_reg.run], "reported winner run is not active")
    `LTKM_ASSERT_IMP(a_leaf_build, clk, rst_n, state_reg == ST_LEAF, building_reg, "leaf fetch outside a tree build")
    `LTKM_ASSERT_NXT(a_adv_walk, clk, rst_n, s_acc && (in_op == OP_ADVANCE) && merging_reg && win_reg.act, state_reg == ST_WALK, "advance did not start a path replay")

endmodule

`default_nettype wire

[tb/sv/ltkm_merge_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Loser tree merge checker
// Watches the config, request and result channels of the k-way merge. Keeps
// its own copy of run heads, active flags and loser nodes, replays the
// tournament for each start, and each advance or exhaust in a merge, and
// compares each result, field by field, against the oldest predicted winner.
// ---------------------------------------------------------------------------

module ltkm_merge_checker
    import ltkm_pkg::*;
#(
    parameter int WAYS     = 8,
    parameter int KEY_BITS = 32,
    parameter int TDATA_W  = 40
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    input  wire logic [OP_W-1:0]    s_axis_tuser,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic [0:0]         m_axis_tuser,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic [RUN_FIELD_W-1:0] run;
        logic [KEY_BITS-1:0]    key;
        logic                   done;
    } winner_t;

    winner_t             winner_q[$];

    logic [KEY_BITS-1:0] head_key [WAYS];
    bit                  run_live [WAYS];
    int                  node_run [WAYS];
    bit                  node_ok  [WAYS];
    bit                  merge_on;
    logic [CFG_W-1:0]    run_count;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic int active_limit();
        return (run_count > WAYS) ? WAYS : int'(run_count);
    endfunction

    // true when run a beats run b
    function automatic bit beats(int a, int b);
        if (run_live[a] != run_live[b])
            return run_live[a];
        if (run_live[a] && head_key[a] != head_key[b])
            return $signed(head_key[a]) < $signed(head_key[b]);
        return a < b;
    endfunction

    function automatic void replay_path(int leaf);
        int cur;
        bit cur_ok;
        int t;
        bit swap;
        int tn;
        bit tv;
        cur    = leaf;
        cur_ok = 1'b1;
        t      = (leaf + WAYS) >> 1;
        while (t > 0)
        begin
            if (!node_ok[t])
                swap = 1'b1;
            else if (!cur_ok)
                swap = 1'b0;
            else
                swap = beats(node_run[t], cur);
            if (swap)
            begin
                tn          = node_run[t];
                tv          = node_ok[t];
                node_run[t] = cur;
                node_ok[t]  = cur_ok;
                cur         = tn;
                cur_ok      = tv;
            end
            t = t >> 1;
        end
        node_run[0] = cur;
        node_ok[0]  = cur_ok;
    endfunction

    function automatic winner_t current_winner();
        winner_t res;
        int      w;
        w = node_run[0] % WAYS;
        if (!node_ok[0] || !run_live[w])
            res = '{run: '0, key: '0, done: 1'b1};
        else
            res = '{run: RUN_FIELD_W'(w), key: head_key[w], done: 1'b0};
        return res;
    endfunction

    function automatic void apply_request(logic [OP_W-1:0] op, int idx,
                                          logic [KEY_BITS-1:0] key);
        int lim;
        int w;
        lim = active_limit();
        case (op)
            OP_LOAD:
            begin
                if (idx < lim)
                begin
                    head_key[idx] = key;
                    run_live[idx] = 1'b1;
                    merge_on      = 1'b0;
                end
            end
            OP_START:
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    if (i >= lim)
                        run_live[i] = 1'b0;
                    node_ok[i] = 1'b0;
                end
                for (int i = WAYS; i > 0; i--)
                    replay_path(i - 1);
                merge_on = 1'b1;
                winner_q.push_back(current_winner());
            end
            default:
            begin
                if (merge_on)
                begin
                    w = node_run[0] % WAYS;
                    if (node_ok[0] && run_live[w])
                    begin
                        if (op == OP_ADVANCE)
                            head_key[w] = key;
                        else
                            run_live[w] = 1'b0;
                        replay_path(w);
                    end
                    winner_q.push_back(current_winner());
                end
            end
        endcase
    endfunction

    function automatic void check_result();
        winner_t got;
        winner_t exp_w;
        got.run  = m_axis_tdata[RUN_FIELD_W-1:0];
        got.key  = m_axis_tdata[RUN_FIELD_W +: KEY_BITS];
        got.done = m_axis_tuser[0];
        if (winner_q.size() == 0)
        begin
            $display("%0t: unexpected result, got run %0d key %0d done %0b",
                     $time, got.run, $signed(got.key), got.done);
            fail_count++;
            return;
        end
        exp_w = winner_q.pop_front();
        if (got !== exp_w)
        begin
            if (got.run !== exp_w.run)
                $display("%0t: winner_run mismatch, expected %0d, got %0d",
                         $time, exp_w.run, got.run);
            if (got.key !== exp_w.key)
                $display("%0t: winner_key mismatch, expected %0d, got %0d",
                         $time, $signed(exp_w.key), $signed(got.key));
            if (got.done !== exp_w.done)
                $display("%0t: all_done mismatch, expected %0b, got %0b",
                         $time, exp_w.done, got.done);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                head_key[i] = '0;
                run_live[i] = 1'b0;
                node_run[i] = 0;
                node_ok[i]  = 1'b0;
            end
            merge_on  = 1'b0;
            run_count = RUN_COUNT_RST;
            winner_q.delete();
            pending   = 0;
        end
        else
        begin
            // a result leaving now always belongs to an earlier request
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                run_count = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                apply_request(s_axis_tuser, int'(s_axis_tdata[RUN_FIELD_W-1:0]),
                              s_axis_tdata[RUN_FIELD_W +: KEY_BITS]);
            pending = winner_q.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Loser tree k-way merge testbench
// Drives loads, starts, advances and exhausts into the merge, first a short
// directed sequence covering key extremes, ties, aborted and idle merges and
// odd run counts, then random merges with random run counts. Both stream
// sides idle in random bursts; the checker scores every result.
// ---------------------------------------------------------------------------

module tb;
    import ltkm_pkg::*;

    localparam int WAYS        = 8;
    localparam int KEY_BITS    = 32;
    localparam int TDATA_W     = ((RUN_FIELD_W + KEY_BITS + 7) / 8) * 8;
    localparam int ITEM_TARGET = 2000;
    localparam int CALM_AFTER  = 1700;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam logic [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_valid     = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data      = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;     // run_index, key, zero pad
    logic [OP_W-1:0]    s_axis_tuser  = OP_LOAD; // operation
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;            // winner_run, winner_key, zero pad
    logic [0:0]         m_axis_tuser;            // all_done

    int fail_count;
    int pending;
    int cycles     = 0;
    int items_sent = 0;
    bit idling_on  = 1'b1;
    bit gaps_on    = 1'b1;
    int cur_count  = 8;

    always #5 clk = ~clk;

    loser_tree_kway_merge #(
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ltkm_merge_checker #(
        .WAYS     (WAYS),
        .KEY_BITS (KEY_BITS),
        .TDATA_W  (TDATA_W)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12) - 1) @(negedge clk);
            end
        end
    end

    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2, 3:    return KEY_BITS'($urandom_range(0, 15)) - KEY_BITS'(8);
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic [OP_W-1:0] op, input logic [2:0] idx,
                            input logic [KEY_BITS-1:0] key);
        if (idling_on && gaps_on && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(TDATA_W-RUN_FIELD_W-KEY_BITS){1'b0}}, key, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
        if (items_sent > CALM_AFTER)
            idling_on = 1'b0;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op);
        send_req(op, 3'($urandom), KEY_BITS'($urandom));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_count(input logic [CFG_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_count = int'(value);
    endtask

    function automatic logic [CFG_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return CFG_W'(1);
            1:       return CFG_W'(WAYS);
            2:       return CFG_W'(0);
            3:       return CFG_W'($urandom_range(WAYS + 1, 15));
            default: return CFG_W'($urandom_range(1, WAYS));
        endcase
    endfunction

    task automatic random_merge();
        int lim;
        int steps;
        int r;
        gaps_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 1) == 1)
            write_count(pick_count());
        lim = (cur_count > WAYS) ? WAYS : cur_count;
        for (int i = 0; i < WAYS; i++)
        begin
            if ($urandom_range(0, 7) != 0)
                send_req(OP_LOAD, 3'(i), pick_key());
        end
        if ($urandom_range(0, 3) == 0)
            send_req(OP_LOAD, 3'($urandom), pick_key());
        send_op(OP_START);
        steps = $urandom_range(lim + 1, 4 * lim + 4);
        repeat (steps)
        begin
            r = $urandom_range(0, 39);
            if (r == 0)
                send_req(OP_LOAD, 3'($urandom), pick_key());
            else if (r == 1)
                send_op(OP_START);
            else if (r < 12)
                send_op(OP_EXHAUST);
            else
                send_req(OP_ADVANCE, 3'($urandom), pick_key());
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_count(CFG_W'(WAYS));
        // advance and exhaust outside a merge
        send_op(OP_ADVANCE);
        send_op(OP_EXHAUST);
        // key extremes and a tie between runs 1 and 2
        send_req(OP_LOAD, 3'd0, KEY_MAX);
        send_req(OP_LOAD, 3'd1, KEY_MIN);
        send_req(OP_LOAD, 3'd2, KEY_MIN);
        send_req(OP_LOAD, 3'd7, '1);
        send_req(OP_LOAD, 3'd3, '0);
        send_op(OP_START);
        send_req(OP_ADVANCE, 3'd5, KEY_MIN);
        send_op(OP_EXHAUST);
        send_op(OP_EXHAUST);
        send_req(OP_ADVANCE, 3'd0, KEY_BITS'(5));
        send_op(OP_EXHAUST);
        send_op(OP_EXHAUST);
        send_op(OP_EXHAUST);
        // nothing left active
        send_op(OP_EXHAUST);
        send_req(OP_ADVANCE, 3'd6, KEY_MAX);
        // a load aborts the merge, run 4 stays over into the next one
        send_req(OP_LOAD, 3'd4, KEY_BITS'(10));
        send_op(OP_ADVANCE);
        send_req(OP_LOAD, 3'd0, KEY_BITS'(2));
        send_op(OP_START);
        send_op(OP_EXHAUST);
        // smaller count drops the stale run, out of range load ignored
        write_count(CFG_W'(3));
        send_req(OP_LOAD, 3'd5, KEY_BITS'(99));
        send_req(OP_LOAD, 3'd1, -KEY_BITS'(7));
        send_op(OP_START);
        send_op(OP_EXHAUST);
        // zero count
        write_count(CFG_W'(0));
        send_req(OP_LOAD, 3'd0, KEY_BITS'(1));
        send_op(OP_START);
        // count above the number of runs
        write_count(CFG_W'(12));
        send_req(OP_LOAD, 3'd7, KEY_BITS'(3));
        send_op(OP_START);
        send_req(OP_ADVANCE, 3'd2, KEY_MAX);

        while (items_sent < ITEM_TARGET)
            random_merge();

        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ltkm_pkg.sv
hw/rtl/loser_tree_kway_merge.sv
tb/sv/ltkm_merge_checker.sv
tb/sv/tb.sv
